>>> rtl/raf_pkg.sv
// ----------------------------------------------------------------------------
// raf_pkg: shared types and constants of the radix ascii formatter
// control and datapath codes used by the formatter and its sub-blocks
// ----------------------------------------------------------------------------
package raf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    // most characters an item can produce, and the width of a digit count
    localparam int MAX_CHARS = 32;
    localparam int CNT_W     = 6;

    // format codes on the func port, 5 to 7 are spare and act as unsigned
    typedef enum logic [2:0] {
        FMT_UDEC,
        FMT_SDEC,
        FMT_HEX,
        FMT_OCT,
        FMT_BIN,
        FMT_SPARE5,
        FMT_SPARE6,
        FMT_SPARE7
    } fmt_t;

    // digit size in the emitter shift register
    typedef enum logic [1:0] {
        DS_BIN,
        DS_OCT,
        DS_HEX
    } dsize_t;

    // top level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_CONV,
        ST_WAIT
    } ctl_state_t;

    // emitter sequencer
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_SIGN,
        EM_DIGIT
    } em_state_t;

    // load command from the control to the emitter
    typedef struct packed {
        logic             load;
        dsize_t           dsize;
        logic             sign;
        logic             fixed;
        logic [CNT_W-1:0] ndig;
        logic [CNT_W-1:0] keep;
    } emit_cmd_t;

    // decimal digits needed for 2^w - 1
    function automatic int dec_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

endpackage

>>> rtl/radix_ascii_formatter.sv
// ----------------------------------------------------------------------------
// radix_ascii_formatter: number to ascii character stream
// formats a value as unsigned or signed decimal, hex, octal or binary
// ----------------------------------------------------------------------------
// One item in gives a stream of ASCII characters out, most significant digit
// first, with last set on the final one. func selects the format: 0 unsigned
// decimal, 1 signed decimal (a '-' ahead of the magnitude of a negative
// value), 2 upper-case hex, 3 octal, 4 binary of bin_digits low bits (0 is
// taken as 1, above 32 as 32); codes 5 to 7 act as unsigned decimal. Only the
// low VALUE_WIDTH bits of value are used. Decimal, hex and octal drop leading
// zeros, and zero prints as a single '0'. The block works on one item at a
// time and holds in_stall high until the last character of that item has been
// taken. A decimal item first runs through the bit-serial bcd converter; hex,
// octal and binary skip it. Leading digits are then dropped in the shift
// register, for binary the bit positions above bin_digits of the 32, and the
// register gives one character per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module radix_ascii_formatter #(
    parameter int VALUE_WIDTH = raf_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    input  logic [2:0]  func,
    input  logic [5:0]  bin_digits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  char_code,
    output logic        last
);

    localparam int DEC_DIGITS = raf_pkg::dec_digits(VALUE_WIDTH);
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int HEX_D      = (VALUE_WIDTH + 3) / 4;
    localparam int OCT_D      = (VALUE_WIDTH + 2) / 3;
    localparam int BIN_D      = raf_pkg::MAX_CHARS;
    // digit shift register: wide enough for the bcd digits and for 32 bits
    localparam int SR_W       = (BCD_W > BIN_D) ? BCD_W : BIN_D;

    raf_pkg::ctl_state_t        state_reg;
    raf_pkg::ctl_state_t        state_next;
    logic [VALUE_WIDTH-1:0]     v_reg;
    logic [2:0]                 func_reg;
    logic [raf_pkg::CNT_W-1:0]  nbd_reg;
    logic [raf_pkg::CNT_W-1:0]  nbd_clamped;
    logic [63:0]                value_ext;
    logic [63:0]                v_ext;
    logic                       accept;
    logic                       is_dec;
    logic                       neg;
    logic [VALUE_WIDTH-1:0]     mag;
    logic                       conv_start;
    logic                       conv_done;
    logic [BCD_W-1:0]           bcd;
    raf_pkg::emit_cmd_t         cmd;
    logic [SR_W-1:0]            sr_load;
    logic                       em_idle;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != raf_pkg::ST_IDLE);

    // value trimmed or zero-extended to the working width
    assign value_ext = 64'(value);
    assign v_ext     = 64'(v_reg);

    // binary digit count: zero means one, anything past 32 saturates
    always_comb
    begin
        if (bin_digits == 6'd0)
            nbd_clamped = raf_pkg::CNT_W'(1);
        else if (bin_digits > 6'(BIN_D))
            nbd_clamped = raf_pkg::CNT_W'(BIN_D);
        else
            nbd_clamped = raf_pkg::CNT_W'(bin_digits);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg    <= value_ext[VALUE_WIDTH-1:0];
            func_reg <= func;
            nbd_reg  <= nbd_clamped;
        end
    end

    // format decode; the magnitude wraps for the most negative value
    assign is_dec = (func_reg != raf_pkg::FMT_HEX) && (func_reg != raf_pkg::FMT_OCT)
                 && (func_reg != raf_pkg::FMT_BIN);
    assign neg    = (func_reg == raf_pkg::FMT_SDEC) && v_reg[VALUE_WIDTH-1];
    assign mag    = neg ? (~v_reg + 1'b1) : v_reg;

    assign conv_start = (state_reg == raf_pkg::ST_PREP) && is_dec;

    raf_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .bin   (mag),
        .done  (conv_done),
        .bcd   (bcd)
    );

    // load command: hex, octal and binary straight from the item, decimal
    // once the converter is done; digits are left-aligned in the register
    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.dsize = raf_pkg::DS_HEX;
        cmd.sign  = 1'b0;
        cmd.fixed = 1'b0;
        cmd.ndig  = raf_pkg::CNT_W'(DEC_DIGITS);
        cmd.keep  = raf_pkg::CNT_W'(1);
        sr_load   = SR_W'(bcd) << (SR_W - BCD_W);
        if (state_reg == raf_pkg::ST_CONV)
        begin
            cmd.load = conv_done;
            cmd.sign = neg;
        end
        else if (state_reg == raf_pkg::ST_PREP)
        begin
            cmd.load = !is_dec;
            case (func_reg)
                raf_pkg::FMT_HEX:
                begin
                    cmd.dsize = raf_pkg::DS_HEX;
                    cmd.ndig  = raf_pkg::CNT_W'(HEX_D);
                    sr_load   = SR_W'(v_reg) << (SR_W - 4 * HEX_D);
                end
                raf_pkg::FMT_OCT:
                begin
                    cmd.dsize = raf_pkg::DS_OCT;
                    cmd.ndig  = raf_pkg::CNT_W'(OCT_D);
                    sr_load   = SR_W'(v_reg) << (SR_W - 3 * OCT_D);
                end
                raf_pkg::FMT_BIN:
                begin
                    // bit 31 at the top, unused high bits drop as a fixed count
                    cmd.dsize = raf_pkg::DS_BIN;
                    cmd.fixed = 1'b1;
                    cmd.ndig  = raf_pkg::CNT_W'(BIN_D);
                    cmd.keep  = nbd_reg;
                    sr_load   = SR_W'(v_ext[BIN_D-1:0]) << (SR_W - BIN_D);
                end
                default:
                begin
                    cmd.load = 1'b0;
                end
            endcase
        end
    end

    raf_emitter #(
        .SR_W (SR_W)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sr_in     (sr_load),
        .idle      (em_idle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            raf_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = raf_pkg::ST_PREP;
            end
            raf_pkg::ST_PREP:
            begin
                state_next = is_dec ? raf_pkg::ST_CONV : raf_pkg::ST_WAIT;
            end
            raf_pkg::ST_CONV:
            begin
                if (conv_done)
                    state_next = raf_pkg::ST_WAIT;
            end
            raf_pkg::ST_WAIT:
            begin
                // emitter leaves idle the cycle after its load
                if (em_idle)
                    state_next = raf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = raf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= raf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    // an accepted item closes the input until it is fully delivered
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after an item was taken");

    // characters only appear while an item is being delivered
    a_out_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == raf_pkg::ST_WAIT))
        else $error("character shown outside delivery");
`endif

endmodule

>>> rtl/raf_dabble.sv
// ----------------------------------------------------------------------------
// raf_dabble: bit-serial binary to bcd converter
// shift-and-add-3, one input bit per cycle, msb first
// ----------------------------------------------------------------------------
module raf_dabble #(
    parameter int VALUE_WIDTH = raf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               start,
    input  logic [VALUE_WIDTH-1:0]                             bin,
    output logic                                               done,
    output logic [4*raf_pkg::dec_digits(VALUE_WIDTH)-1:0]      bcd
);

    localparam int DEC_DIGITS = raf_pkg::dec_digits(VALUE_WIDTH);
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int CW         = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       adj;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(VALUE_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= bin_reg << 1;
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

`ifndef SYNTHESIS
    // every input bit has been shifted in once the result is flagged
    a_bits_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (bin_reg == '0))
        else $error("bcd done with input bits left");
`endif

endmodule

>>> rtl/raf_emitter.sv
// ----------------------------------------------------------------------------
// raf_emitter: digit shift register and character output stage
// drops leading digits, emits the sign, then one character per cycle while
// out_stall is low
module raf_emitter #(
    parameter int SR_W = raf_pkg::MAX_CHARS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  raf_pkg::emit_cmd_t cmd,
    input  logic [SR_W-1:0]    sr_in,
    output logic               idle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [6:0]         char_code,
    output logic               last
);

    localparam logic [6:0] ASCII_ZERO   = 7'd48;
    localparam logic [6:0] ASCII_LETTER = 7'd55;
    localparam logic [6:0] ASCII_MINUS  = 7'd45;

    raf_pkg::em_state_t            state_reg;
    raf_pkg::em_state_t            state_next;
    logic [SR_W-1:0]               sr_reg;
    logic [SR_W-1:0]               sr_shifted;
    logic [raf_pkg::CNT_W-1:0]     cnt_reg;
    logic [raf_pkg::CNT_W-1:0]     keep_reg;
    raf_pkg::dsize_t               dsize_reg;
    logic                          sign_reg;
    logic                          fixed_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [6:0]                    char_reg;
    logic                          last_reg;
    logic [3:0]                    top_digit;
    logic [6:0]                    digit_char;
    logic                          skip;
    logic                          slot_free;
    logic                          shift_en;
    logic                          emit_sign;
    logic                          emit_digit;

    // digit at the top of the shift register, and the shift to the next one
    always_comb
    begin
        case (dsize_reg)
            raf_pkg::DS_BIN:
            begin
                top_digit  = {3'b000, sr_reg[SR_W-1]};
                sr_shifted = sr_reg << 1;
            end
            raf_pkg::DS_OCT:
            begin
                top_digit  = {1'b0, sr_reg[SR_W-1 -: 3]};
                sr_shifted = sr_reg << 3;
            end
            default:
            begin
                top_digit  = sr_reg[SR_W-1 -: 4];
                sr_shifted = sr_reg << 4;
            end
        endcase
    end

    assign digit_char = (top_digit < 4'd10) ? ({3'b000, top_digit} + ASCII_ZERO)
                                            : ({3'b000, top_digit} + ASCII_LETTER);

    // binary drops a fixed count, the others drop zeros down to one digit
    assign skip      = (cnt_reg > keep_reg) && (fixed_reg || (top_digit == 4'd0));
    assign slot_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            raf_pkg::EM_IDLE:
            begin
                if (cmd.load)
                    state_next = raf_pkg::EM_SKIP;
            end
            raf_pkg::EM_SKIP:
            begin
                if (!skip)
                    state_next = sign_reg ? raf_pkg::EM_SIGN : raf_pkg::EM_DIGIT;
            end
            raf_pkg::EM_SIGN:
            begin
                if (slot_free)
                    state_next = raf_pkg::EM_DIGIT;
            end
            raf_pkg::EM_DIGIT:
            begin
                if (slot_free && (cnt_reg == raf_pkg::CNT_W'(1)))
                    state_next = raf_pkg::EM_IDLE;
            end
            default:
            begin
                state_next = raf_pkg::EM_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        shift_en   = 1'b0;
        emit_sign  = 1'b0;
        emit_digit = 1'b0;
        case (state_reg)
            raf_pkg::EM_SKIP:
            begin
                shift_en = skip;
            end
            raf_pkg::EM_SIGN:
            begin
                emit_sign = slot_free;
            end
            raf_pkg::EM_DIGIT:
            begin
                shift_en   = slot_free;
                emit_digit = slot_free;
            end
            default:
            begin
                shift_en = 1'b0;
            end
        endcase
    end

    assign out_valid_next = (emit_sign || emit_digit) ? 1'b1
                          : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= raf_pkg::EM_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == raf_pkg::EM_IDLE) && cmd.load)
                cnt_reg <= cmd.ndig;
            else if (shift_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == raf_pkg::EM_IDLE) && cmd.load)
        begin
            sr_reg    <= sr_in;
            keep_reg  <= cmd.keep;
            dsize_reg <= cmd.dsize;
            sign_reg  <= cmd.sign;
            fixed_reg <= cmd.fixed;
        end
        else if (shift_en)
        begin
            sr_reg <= sr_shifted;
        end
        if (emit_sign)
        begin
            char_reg <= ASCII_MINUS;
            last_reg <= 1'b0;
        end
        else if (emit_digit)
        begin
            char_reg <= digit_char;
            last_reg <= (cnt_reg == raf_pkg::CNT_W'(1));
        end
    end

    assign idle      = (state_reg == raf_pkg::EM_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // once the final character is out the sequencer has nothing left
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (state_reg == raf_pkg::EM_IDLE))
        else $error("final character shown while digits remain");

    // a digit is never emitted from an empty count
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == raf_pkg::EM_DIGIT) || (state_reg == raf_pkg::EM_SKIP))
        |-> (cnt_reg != '0))
        else $error("digit count ran out");
`endif

endmodule
